// ===== rtl/mlpwp_pkg.sv =====
// Package for the sliding-window perceptron predictor.
// Holds the payload structs, the step kinds of the shared MAC unit and the tanh table.
// No dependencies.
`default_nettype none
package mlpwp_pkg;

    localparam int WINDOW       = 16;
    localparam int HIDDEN       = 32;
    localparam int SW           = 16;
    localparam int FRAC         = SW - 4;
    localparam int TANH_ENTRIES = 256;
    localparam int ADDR_W       = 10;
    localparam int MEM_DEPTH    = WINDOW * HIDDEN + 2 * HIDDEN + 1;
    localparam int HB_BASE      = WINDOW * HIDDEN;
    localparam int OW_BASE      = HB_BASE + HIDDEN;
    localparam int OB_ADDR      = OW_BASE + HIDDEN;
    localparam int ACC_W        = 24;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Step kinds of the shared multiply-accumulate unit.
    localparam logic [1:0] K_LOAD_H = 2'd0;
    localparam logic [1:0] K_MAC_H  = 2'd1;
    localparam logic [1:0] K_LOAD_Y = 2'd2;
    localparam logic [1:0] K_MAC_Y  = 2'd3;

    typedef struct packed {
        logic                  operation;
        logic [ADDR_W-1:0]     weight_address;
        logic signed [SW-1:0]  weight_value;
        logic signed [SW-1:0]  sample;
    } t_in;

    typedef struct packed {
        logic signed [SW-1:0]  prediction;
        logic                  saturated;
    } t_out;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
    } t_mac_ctl;

    typedef logic signed [SW-1:0] t_tanh_tab [TANH_ENTRIES];

    // Restoring divider used only while the table is built at elaboration.
    function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry k holds tanh at the bin midpoint, built by the integer series procedure.
    function automatic t_tanh_tab build_tanh();
        t_tanh_tab   tab;
        logic [63:0] one;
        logic [63:0] m;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] prod;
        logic [63:0] dd;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] t;
        int          d;
        one = 64'd1 << 30;
        for (int k = 0; k < TANH_ENTRIES; k++) begin
            d    = 2 * k + 1 - TANH_ENTRIES;
            m    = 64'((d < 0) ? -d : d);
            y    = (m << 29) >> $clog2(TANH_ENTRIES);
            term = one;
            sum  = one;
            for (int n = 1; n <= 24; n++) begin
                prod = term * y;
                term = udiv(prod >> 30, 64'(n));
                sum  = sum + term;
            end
            dd = udiv(64'd1 << 60, sum);
            for (int n = 0; n < 4; n++) begin
                dd = (dd * dd) >> 30;
            end
            num = (one - dd) << FRAC;
            den = one + dd;
            t   = udiv(num + (den >> 1), den);
            tab[k] = (d < 0) ? -SW'(t) : SW'(t);
        end
        return tab;
    endfunction

    localparam t_tanh_tab TANH_TAB = build_tanh();

endpackage
`default_nettype wire

// ===== rtl/mlpwp_mac.sv =====
// Shared multiply-accumulate unit: one registered product, then rounding and accumulation.
// Keeps the hidden sum and the output sum. Depends on mlpwp_pkg.
`default_nettype none
module mlpwp_mac (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire mlpwp_pkg::t_mac_ctl                    i_ctl,
    input  wire logic signed [mlpwp_pkg::SW-1:0]        i_a,
    input  wire logic signed [mlpwp_pkg::SW-1:0]        i_b,
    output logic signed [mlpwp_pkg::ACC_W-1:0]          o_h,
    output logic signed [mlpwp_pkg::ACC_W-1:0]          o_acc
);
    localparam int PW = 2 * mlpwp_pkg::SW;
    localparam int RW = PW + 1 - mlpwp_pkg::FRAC;

    logic                               r_v1;
    logic [1:0]                         r_k1;
    logic signed [PW-1:0]               r_prod;
    logic signed [mlpwp_pkg::ACC_W-1:0] r_h;
    logic signed [mlpwp_pkg::ACC_W-1:0] r_acc;
    logic signed [PW-1:0]               w_mul;
    logic signed [PW:0]                 w_sum;
    logic signed [mlpwp_pkg::ACC_W-1:0] w_rnd;
    logic signed [mlpwp_pkg::ACC_W-1:0] w_ld;

    assign w_mul = i_a * i_b;
    // Round half up: add half an LSB, then floor shift.
    assign w_sum = {r_prod[PW-1], r_prod} + (PW+1)'(1 << (mlpwp_pkg::FRAC - 1));
    assign w_rnd = {{(mlpwp_pkg::ACC_W-RW){w_sum[PW]}}, w_sum[PW:mlpwp_pkg::FRAC]};
    assign w_ld  = {{(mlpwp_pkg::ACC_W-mlpwp_pkg::SW){r_prod[mlpwp_pkg::SW-1]}},
                    r_prod[mlpwp_pkg::SW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.valid;
        end
        r_k1 <= i_ctl.kind;
        if (i_ctl.kind == mlpwp_pkg::K_LOAD_H || i_ctl.kind == mlpwp_pkg::K_LOAD_Y) begin
            r_prod <= {{(PW-mlpwp_pkg::SW){i_b[mlpwp_pkg::SW-1]}}, i_b};
        end else begin
            r_prod <= w_mul;
        end
        if (r_v1) begin
            unique case (r_k1)
                mlpwp_pkg::K_LOAD_H: r_h   <= w_ld;
                mlpwp_pkg::K_MAC_H:  r_h   <= r_h + w_rnd;
                mlpwp_pkg::K_LOAD_Y: r_acc <= w_ld;
                mlpwp_pkg::K_MAC_Y:  r_acc <= r_acc + w_rnd;
                default:             r_h   <= r_h;
            endcase
        end
    end

    assign o_h   = r_h;
    assign o_acc = r_acc;
endmodule
`default_nettype wire

// ===== rtl/mlp_window_predictor.sv =====
// Top level of the sliding-window perceptron predictor: weight memory, sample window,
// sequencer and output register. Depends on mlpwp_pkg and mlpwp_mac.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready / i_in_data) carries weight writes and
//   samples. A weight write stores one word and gives no result;
//   addresses above the output bias are dropped. A sample is shifted into the
//   16-deep window; from the sixteenth sample on, each sample gives one prediction
//   on the output channel (o_out_valid / i_out_ready / o_out_data).
//   For a prediction the sequencer first loads the output bias, then for each hidden
//   unit loads its bias, adds its 16 window products, waits for the sum to settle,
//   looks up tanh and adds one output product; at the end it drains the last product
//   into the sum and loads the output register.
//   One multiply-accumulate unit serves every product, with one weight memory read
//   per cycle. o_in_ready is high only while the sequencer is idle, so the next item
//   can be taken in the cycle after the result is loaded.
//   The result waits in an output register; the next item is taken while it waits.
//   If the receiver stalls, a finished prediction holds the sequencer until the
//   register frees up. Reset empties the window and the fill count. Weights are
//   undefined until written and must all be written before the first prediction.
`default_nettype none
module mlp_window_predictor (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire mlpwp_pkg::t_in     i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output mlpwp_pkg::t_out         o_out_data
);
    localparam int SW   = mlpwp_pkg::SW;
    localparam int AW   = mlpwp_pkg::ACC_W;
    localparam int UW   = $clog2(mlpwp_pkg::HIDDEN);
    localparam int JW   = $clog2(mlpwp_pkg::WINDOW);
    localparam int FW   = $clog2(mlpwp_pkg::WINDOW + 1);
    localparam int TW   = $clog2(mlpwp_pkg::TANH_ENTRIES);
    localparam int AWD  = mlpwp_pkg::ADDR_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRE   = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [4:0] STEP_BIAS = 5'd0;
    localparam logic [4:0] STEP_LAST = 5'd16;
    localparam logic [4:0] STEP_OUT  = 5'd19;

    localparam logic signed [AW-1:0] SMAX = AW'((1 << (SW - 1)) - 1);
    localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);
    localparam logic signed [SW-1:0] LIM  = SW'(1 << (mlpwp_pkg::FRAC + 2));

    logic signed [SW-1:0]  r_mem [mlpwp_pkg::MEM_DEPTH];
    logic signed [SW-1:0]  r_rdata;
    logic signed [SW-1:0]  r_win [mlpwp_pkg::WINDOW];
    logic [FW-1:0]         r_fill;
    logic [FW-1:0]         n_fill;
    logic [2:0]            r_state;
    logic [UW-1:0]         r_unit;
    logic [4:0]            r_step;
    logic [1:0]            r_drain;
    logic                  r_flag;
    logic signed [SW-1:0]  r_tanh;
    logic                  r_iss_v;
    logic [1:0]            r_iss_kind;
    logic [JW-1:0]         r_iss_j;
    logic                  r_out_valid;
    mlpwp_pkg::t_out       r_out_data;

    logic                  iss_v;
    logic [1:0]            iss_kind;
    logic [AWD-1:0]        iss_addr;
    logic [JW-1:0]         iss_j;
    logic [4:0]            step_m1;
    logic                  in_xfer;
    logic                  out_free;
    mlpwp_pkg::t_mac_ctl   mac_ctl;
    logic signed [SW-1:0]  mac_a;
    logic signed [AW-1:0]  mac_h;
    logic signed [AW-1:0]  mac_acc;
    logic signed [SW-1:0]  h_sat;
    logic                  h_ovf;
    logic signed [SW-1:0]  y_sat;
    logic                  y_ovf;
    logic signed [SW-1:0]  h_off;
    logic [TW-1:0]         t_idx;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign n_fill     = (r_fill < FW'(mlpwp_pkg::WINDOW)) ? r_fill + FW'(1) : r_fill;
    assign step_m1    = r_step - 5'd1;

    // Step schedule of the sequencer.
    always_comb begin
        iss_v    = 1'b0;
        iss_kind = mlpwp_pkg::K_MAC_H;
        iss_addr = '0;
        iss_j    = step_m1[JW-1:0];
        if (r_state == ST_PRE) begin
            iss_v    = 1'b1;
            iss_kind = mlpwp_pkg::K_LOAD_Y;
            iss_addr = AWD'(mlpwp_pkg::OB_ADDR);
        end else if (r_state == ST_RUN) begin
            if (r_step == STEP_BIAS) begin
                iss_v    = 1'b1;
                iss_kind = mlpwp_pkg::K_LOAD_H;
                iss_addr = AWD'(mlpwp_pkg::HB_BASE) + AWD'(r_unit);
            end else if (r_step <= STEP_LAST) begin
                iss_v    = 1'b1;
                iss_kind = mlpwp_pkg::K_MAC_H;
                iss_addr = AWD'({step_m1[JW-1:0], r_unit});
            end else if (r_step == STEP_OUT) begin
                iss_v    = 1'b1;
                iss_kind = mlpwp_pkg::K_MAC_Y;
                iss_addr = AWD'(mlpwp_pkg::OW_BASE) + AWD'(r_unit);
            end
        end
    end

    // Saturation of the hidden and output sums, and tanh index of the finished hidden sum.
    always_comb begin
        h_ovf = (mac_h > SMAX) || (mac_h < SMIN);
        h_sat = (mac_h > SMAX) ? SMAX[SW-1:0] :
                (mac_h < SMIN) ? SMIN[SW-1:0] : mac_h[SW-1:0];
        y_ovf = (mac_acc > SMAX) || (mac_acc < SMIN);
        y_sat = (mac_acc > SMAX) ? SMAX[SW-1:0] :
                (mac_acc < SMIN) ? SMIN[SW-1:0] : mac_acc[SW-1:0];
        h_off = h_sat + LIM;
        if (h_sat < -LIM) begin
            t_idx = '0;
        end else if (h_sat >= LIM) begin
            t_idx = '1;
        end else begin
            t_idx = h_off[mlpwp_pkg::FRAC+2:mlpwp_pkg::FRAC+3-TW];
        end
    end

    // Weight memory: one write port for loading, one registered read port for the unit.
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in_data.operation == mlpwp_pkg::OP_WRITE &&
            i_in_data.weight_address <= AWD'(mlpwp_pkg::OB_ADDR)) begin
            r_mem[i_in_data.weight_address] <= i_in_data.weight_value;
        end
        r_rdata <= r_mem[iss_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mlpwp_pkg::WINDOW; i++) begin
                r_win[i] <= '0;
            end
            r_fill      <= '0;
            r_state     <= ST_IDLE;
            r_unit      <= '0;
            r_step      <= '0;
            r_drain     <= '0;
            r_flag      <= 1'b0;
            r_iss_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_iss_v <= iss_v;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer && i_in_data.operation == mlpwp_pkg::OP_SAMPLE) begin
                        for (int i = 0; i < mlpwp_pkg::WINDOW - 1; i++) begin
                            r_win[i] <= r_win[i+1];
                        end
                        r_win[mlpwp_pkg::WINDOW-1] <= i_in_data.sample;
                        r_fill <= n_fill;
                        if (n_fill == FW'(mlpwp_pkg::WINDOW)) begin
                            r_state <= ST_PRE;
                        end
                    end
                end
                ST_PRE: begin
                    r_flag  <= 1'b0;
                    r_unit  <= '0;
                    r_step  <= '0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (r_step == STEP_OUT) begin
                        r_step <= '0;
                        r_unit <= r_unit + UW'(1);
                        if (h_ovf) begin
                            r_flag <= 1'b1;
                        end
                        if (r_unit == UW'(mlpwp_pkg::HIDDEN - 1)) begin
                            r_drain <= '0;
                            r_state <= ST_DRAIN;
                        end
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                ST_DRAIN: begin
                    // The drain lets the last output product pass the issue and product registers and reach the sum.
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'd1) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss_kind <= iss_kind;
        r_iss_j    <= iss_j;
        if (r_state == ST_RUN && r_step == STEP_OUT) begin
            r_tanh <= mlpwp_pkg::TANH_TAB[t_idx];
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_data.prediction <= y_sat;
            r_out_data.saturated  <= r_flag || y_ovf;
        end
    end

    assign mac_ctl.valid = r_iss_v;
    assign mac_ctl.kind  = r_iss_kind;
    assign mac_a = (r_iss_kind == mlpwp_pkg::K_MAC_Y) ? r_tanh : r_win[r_iss_j];

    mlpwp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (r_rdata),
        .o_h     (mac_h),
        .o_acc   (mac_acc)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(mlpwp_pkg::WINDOW))
        else $error("fill count beyond window depth");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_data.operation == mlpwp_pkg::OP_SAMPLE &&
        r_fill == FW'(mlpwp_pkg::WINDOW - 1) |=> r_state == ST_PRE)
        else $error("full window did not start a prediction");

    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE && out_free |=> r_out_valid && r_state == ST_IDLE)
        else $error("finished prediction not loaded");

    a_no_issue_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !iss_v)
        else $error("unit step issued while idle");
endmodule
`default_nettype wire
